// ===== sv/mrlp_pkg.sv =====
package mrlp_pkg;

    // One character of a literal, as it arrives.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in;

    // One parsed literal, as it leaves.
    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  status;
        logic [2:0]  format;
    } t_out;

    // A character after classification by the front end.
    typedef struct packed {
        logic       last;
        logic       body;     // third or later character: part of a prefixed body
        logic       set_px;   // completes a leading "0x"
        logic       set_pb;   // completes a leading "0b"
        logic [3:0] digit;    // value of the character as a hex digit
        logic       hex_ok;
        logic       bin_ok;
        logic       dec_ok;
        logic       is_h;
        logic       is_b;
    } t_cls;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD      = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam logic [2:0] FMT_HEX_PREFIX = 3'd0;
    localparam logic [2:0] FMT_HEX_SUFFIX = 3'd1;
    localparam logic [2:0] FMT_BIN_PREFIX = 3'd2;
    localparam logic [2:0] FMT_BIN_SUFFIX = 3'd3;
    localparam logic [2:0] FMT_DEC        = 3'd4;

    // Largest decimal accumulator that may still take a further digit.
    localparam logic [63:0] DEC_LIMIT_DIV10 = 64'd1844674407370955161;

endpackage

// ===== sv/mrlp_front.sv =====
module mrlp_front
    import mrlp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_in  i_in,
    input  logic i_push,
    output t_cls o_cls
);

    logic [1:0] r_position;
    logic [1:0] n_position;
    logic [7:0] r_prev_char;
    logic [7:0] n_prev_char;
    logic [7:0] c;
    logic       prefix_slot;

    assign c           = i_in.ch;
    assign prefix_slot = (r_position == 2'd1) && (r_prev_char == "0");

    always_comb begin
        o_cls        = '0;
        o_cls.last   = i_in.last;
        o_cls.body   = (r_position == 2'd2);
        o_cls.set_px = prefix_slot && (c == "x");
        o_cls.set_pb = prefix_slot && (c == "b");
        o_cls.bin_ok = (c == "0") || (c == "1");
        o_cls.dec_ok = (c >= "0") && (c <= "9");
        o_cls.is_h   = (c == "H") || (c == "h");
        o_cls.is_b   = (c == "B") || (c == "b");
        if ((c >= "0") && (c <= "9")) begin
            o_cls.hex_ok = 1'b1;
            o_cls.digit  = 4'(c - 8'h30);
        end else if ((c >= "A") && (c <= "F")) begin
            o_cls.hex_ok = 1'b1;
            o_cls.digit  = 4'(c - 8'h37);
        end else if ((c >= "a") && (c <= "f")) begin
            o_cls.hex_ok = 1'b1;
            o_cls.digit  = 4'(c - 8'h57);
        end
    end

    // The position count saturates at two and starts again after a final character.
    always_comb begin
        n_position  = r_position;
        n_prev_char = r_prev_char;
        if (i_push) begin
            if (i_in.last) begin
                n_position  = 2'd0;
                n_prev_char = 8'd0;
            end else begin
                n_prev_char = c;
                if (r_position != 2'd2) begin
                    n_position = r_position + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position  <= 2'd0;
            r_prev_char <= 8'd0;
        end else begin
            r_position  <= n_position;
            r_prev_char <= n_prev_char;
        end
    end

endmodule

// ===== sv/mrlp_queue.sv =====
module mrlp_queue
    import mrlp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cls i_data,
    input  logic i_pop,
    output t_cls o_data,
    output logic o_full,
    output logic o_empty
);

    t_cls       r_mem [2];
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       r_wr_ptr;
    logic       r_rd_ptr;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= 2'd0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

endmodule

// ===== sv/mrlp_back.sv =====
module mrlp_back
    import mrlp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cls i_cls,
    input  logic i_q_empty,
    output logic o_pop,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

    // Bad-body bits, one per format in format order.
    logic [4:0]  r_bad,  n_bad;
    logic [4:0]  r_ovf,  n_ovf;
    logic        r_seen_h, n_seen_h;
    logic        r_seen_b, n_seen_b;
    logic        r_px, n_px;
    logic        r_pb, n_pb;
    logic        r_body_pre, n_body_pre;   // a character after a two-character prefix
    logic        r_body_suf, n_body_suf;   // a character before the final one
    logic [63:0] r_hex0, n_hex0;
    logic [63:0] r_hex1, n_hex1;
    logic [63:0] r_bin0, n_bin0;
    logic [63:0] r_bin1, n_bin1;
    logic [63:0] r_dec,  n_dec;
    logic        r_out_valid;
    t_out        r_out;
    t_out        n_res;
    logic [2:0]  sel;

    assign o_pop       = !i_q_empty && (!i_cls.last || !r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_bad      = r_bad;
        n_ovf      = r_ovf;
        n_seen_h   = r_seen_h;
        n_seen_b   = r_seen_b;
        n_px       = r_px || i_cls.set_px;
        n_pb       = r_pb || i_cls.set_pb;
        n_body_pre = r_body_pre;
        n_body_suf = r_body_suf;
        n_hex0     = r_hex0;
        n_hex1     = r_hex1;
        n_bin0     = r_bin0;
        n_bin1     = r_bin1;
        n_dec      = r_dec;

        if (i_cls.body) begin
            n_body_pre = 1'b1;
            if (i_cls.hex_ok) begin
                n_ovf[0] = r_ovf[0] || (r_hex0[63:60] != 4'd0);
                n_hex0   = {r_hex0[59:0], i_cls.digit};
            end else begin
                n_bad[0] = 1'b1;
            end
            if (i_cls.bin_ok) begin
                n_ovf[2] = r_ovf[2] || r_bin0[63];
                n_bin0   = {r_bin0[62:0], i_cls.digit[0]};
            end else begin
                n_bad[2] = 1'b1;
            end
        end

        if (!i_cls.last) begin
            n_body_suf = 1'b1;
            if (i_cls.hex_ok) begin
                n_ovf[1] = r_ovf[1] || (r_hex1[63:60] != 4'd0);
                n_hex1   = {r_hex1[59:0], i_cls.digit};
            end else begin
                n_bad[1] = 1'b1;
            end
            if (i_cls.bin_ok) begin
                n_ovf[3] = r_ovf[3] || r_bin1[63];
                n_bin1   = {r_bin1[62:0], i_cls.digit[0]};
            end else begin
                n_bad[3] = 1'b1;
            end
            n_seen_h = r_seen_h || i_cls.is_h;
            n_seen_b = r_seen_b || i_cls.is_b;
        end

        // Times ten as two shifted copies, plus the new digit.
        if (i_cls.dec_ok) begin
            n_ovf[4] = r_ovf[4] || (r_dec > DEC_LIMIT_DIV10) ||
                       ((r_dec == DEC_LIMIT_DIV10) && (i_cls.digit > 4'd5));
            n_dec    = {r_dec[60:0], 3'b000} + {r_dec[62:0], 1'b0} + {60'd0, i_cls.digit};
        end else begin
            n_bad[4] = 1'b1;
        end
    end

    // Format priority: 0x prefix, lone H suffix, 0b prefix, lone B suffix, decimal.
    always_comb begin
        logic        empty;
        logic [63:0] val;
        empty = 1'b0;
        val   = n_dec;
        sel   = FMT_DEC;
        if (n_px) begin
            sel   = FMT_HEX_PREFIX;
            empty = !n_body_pre;
            val   = n_hex0;
        end else if (i_cls.is_h && !n_seen_h) begin
            sel   = FMT_HEX_SUFFIX;
            empty = !n_body_suf;
            val   = n_hex1;
        end else if (n_pb) begin
            sel   = FMT_BIN_PREFIX;
            empty = !n_body_pre;
            val   = n_bin0;
        end else if (i_cls.is_b && !n_seen_b) begin
            sel   = FMT_BIN_SUFFIX;
            empty = !n_body_suf;
            val   = n_bin1;
        end
        n_res.format = sel;
        n_res.value  = 64'd0;
        if (n_bad[sel] || empty) begin
            n_res.status = ST_BAD;
        end else if (n_ovf[sel]) begin
            n_res.status = ST_OVERFLOW;
        end else begin
            n_res.status = ST_OK;
            n_res.value  = val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cls.last) begin
            r_out <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (o_pop && i_cls.last)) begin
            r_bad      <= '0;
            r_ovf      <= '0;
            r_seen_h   <= 1'b0;
            r_seen_b   <= 1'b0;
            r_px       <= 1'b0;
            r_pb       <= 1'b0;
            r_body_pre <= 1'b0;
            r_body_suf <= 1'b0;
            r_hex0     <= '0;
            r_hex1     <= '0;
            r_bin0     <= '0;
            r_bin1     <= '0;
            r_dec      <= '0;
        end else if (o_pop) begin
            r_bad      <= n_bad;
            r_ovf      <= n_ovf;
            r_seen_h   <= n_seen_h;
            r_seen_b   <= n_seen_b;
            r_px       <= n_px;
            r_pb       <= n_pb;
            r_body_pre <= n_body_pre;
            r_body_suf <= n_body_suf;
            r_hex0     <= n_hex0;
            r_hex1     <= n_hex1;
            r_bin0     <= n_bin0;
            r_bin1     <= n_bin1;
            r_dec      <= n_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_cls.last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

// ===== sv/multi_radix_literal_parser.sv =====
// Parser for one unsigned 64-bit integer literal, fed one character per request.
// Input channel: i_in_valid, o_in_stall and i_in (character and a final-character
// flag). Output channel: o_out_valid, i_out_stall and o_out (value, status, format).
// Only a request that carries the final character produces an output request.
// The format is 0x prefix, lone H suffix, 0b prefix, lone B suffix or decimal,
// in that order of priority; a bad format is reported ahead of an overflow, and
// the value reads as zero whenever the status is not ok.
// Throughput is one character per cycle while o_in_stall is low. The result of a
// final character is registered in the two-entry queue and then in the back
// end's output register before it shows on o_out_valid; the back end's decimal
// multiply-by-ten-and-add is the longest path.
// Reset clears the position tracking, every accumulator and flag, and o_out_valid,
// and empties the queue; after reset the block is ready at once.
// While the receiver stalls, the result holds still and the back end keeps
// folding characters of the next literal; only the next final character waits,
// and once the queue fills, o_in_stall rises.
module multi_radix_literal_parser
    import mrlp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

    t_cls cls_in;
    t_cls cls_out;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    // The stall depends only on the queue's fill level, never on the valid.
    assign o_in_stall = q_full;
    assign push       = i_in_valid && !q_full;

    // The front end tracks the first two characters to spot a prefix and
    // classifies every character against each radix.
    mrlp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_push  (push),
        .o_cls   (cls_in)
    );

    // A short queue parts the two halves so that each can stall on its own.
    mrlp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cls_in),
        .i_pop   (pop),
        .o_data  (cls_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // The back end folds each character into those of the five accumulators whose
    // body it belongs to, and settles the format and status on the final character.
    mrlp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cls       (cls_out),
        .i_q_empty   (q_empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

// ===== tb/literal_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the literal parser, keeps its own copy of the parse
// state, and compares every result request with the oldest predicted one.
module literal_checker
    import mrlp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_stall,
    input  t_in  i_in,
    input  logic i_out_valid,
    input  logic i_out_stall,
    input  t_out i_out,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);

    // The bad-body and overflow flags are indexed by the format codes.
    logic [1:0]  chars_seen;
    logic [7:0]  prev_ch;
    logic        pfx_hex;
    logic        pfx_bin;
    logic        h_earlier;
    logic        b_earlier;
    logic [4:0]  bad_body;
    logic [4:0]  too_wide;
    logic [63:0] hex_acc [2];
    logic [63:0] bin_acc [2];
    logic [63:0] dec_acc;
    logic        body_after_pfx;
    logic        body_before_last;
    t_out        due_results [$];
    int          fails = 0;
    int          checked = 0;

    task automatic clear_parse();
        chars_seen       = '0;
        prev_ch          = '0;
        pfx_hex          = 1'b0;
        pfx_bin          = 1'b0;
        h_earlier        = 1'b0;
        b_earlier        = 1'b0;
        bad_body         = '0;
        too_wide         = '0;
        hex_acc[0]       = '0;
        hex_acc[1]       = '0;
        bin_acc[0]       = '0;
        bin_acc[1]       = '0;
        dec_acc          = '0;
        body_after_pfx   = 1'b0;
        body_before_last = 1'b0;
    endtask

    // Folds one character into each candidate format whose body holds it; the final
    // character decides which of them is reported.
    task automatic parse_char(input t_in req);
        logic [7:0] c;
        logic [3:0] hv;
        logic [3:0] dv;
        logic       hex_ok;
        logic       bin_ok;
        logic       dec_ok;
        logic       is_h;
        logic       is_b;
        logic       empty;
        logic [2:0] fmt;
        t_out       res;
        c      = req.ch;
        dec_ok = (c >= "0") && (c <= "9");
        bin_ok = (c == "0") || (c == "1");
        is_h   = (c == "H") || (c == "h");
        is_b   = (c == "B") || (c == "b");
        dv     = c[3:0];
        hex_ok = 1'b1;
        if (dec_ok) begin
            hv = dv;
        end else if (c >= "A" && c <= "F") begin
            hv = 4'(c - 8'h41 + 8'd10);
        end else if (c >= "a" && c <= "f") begin
            hv = 4'(c - 8'h61 + 8'd10);
        end else begin
            hex_ok = 1'b0;
            hv     = 4'd0;
        end

        if (chars_seen == 2'd1 && prev_ch == "0") begin
            if (c == "x") pfx_hex = 1'b1;
            if (c == "b") pfx_bin = 1'b1;
        end

        // Third character onwards: body of a prefixed literal.
        if (chars_seen >= 2'd2) begin
            body_after_pfx = 1'b1;
            if (hex_ok) begin
                if (hex_acc[0][63:60] != 4'd0) too_wide[FMT_HEX_PREFIX] = 1'b1;
                hex_acc[0] = {hex_acc[0][59:0], hv};
            end else begin
                bad_body[FMT_HEX_PREFIX] = 1'b1;
            end
            if (bin_ok) begin
                if (bin_acc[0][63]) too_wide[FMT_BIN_PREFIX] = 1'b1;
                bin_acc[0] = {bin_acc[0][62:0], c[0]};
            end else begin
                bad_body[FMT_BIN_PREFIX] = 1'b1;
            end
        end

        // Every character but the final one: body of a suffixed literal.
        if (!req.last) begin
            body_before_last = 1'b1;
            if (hex_ok) begin
                if (hex_acc[1][63:60] != 4'd0) too_wide[FMT_HEX_SUFFIX] = 1'b1;
                hex_acc[1] = {hex_acc[1][59:0], hv};
            end else begin
                bad_body[FMT_HEX_SUFFIX] = 1'b1;
            end
            if (bin_ok) begin
                if (bin_acc[1][63]) too_wide[FMT_BIN_SUFFIX] = 1'b1;
                bin_acc[1] = {bin_acc[1][62:0], c[0]};
            end else begin
                bad_body[FMT_BIN_SUFFIX] = 1'b1;
            end
            if (is_h) h_earlier = 1'b1;
            if (is_b) b_earlier = 1'b1;
        end

        if (dec_ok) begin
            if (dec_acc > DEC_LIMIT_DIV10 || (dec_acc == DEC_LIMIT_DIV10 && dv > 4'd5)) begin
                too_wide[FMT_DEC] = 1'b1;
            end
            dec_acc = dec_acc * 64'd10 + 64'(dv);
        end else begin
            bad_body[FMT_DEC] = 1'b1;
        end

        prev_ch = c;
        if (chars_seen < 2'd2) chars_seen = chars_seen + 2'd1;

        if (req.last) begin
            if (pfx_hex) begin
                fmt = FMT_HEX_PREFIX;
                empty = !body_after_pfx;
                res.value = hex_acc[0];
            end else if (is_h && !h_earlier) begin
                fmt = FMT_HEX_SUFFIX;
                empty = !body_before_last;
                res.value = hex_acc[1];
            end else if (pfx_bin) begin
                fmt = FMT_BIN_PREFIX;
                empty = !body_after_pfx;
                res.value = bin_acc[0];
            end else if (is_b && !b_earlier) begin
                fmt = FMT_BIN_SUFFIX;
                empty = !body_before_last;
                res.value = bin_acc[1];
            end else begin
                fmt = FMT_DEC;
                empty = 1'b0;
                res.value = dec_acc;
            end
            if (bad_body[fmt] || empty) begin
                res.status = ST_BAD;
            end else if (too_wide[fmt]) begin
                res.status = ST_OVERFLOW;
            end else begin
                res.status = ST_OK;
            end
            if (res.status != ST_OK) res.value = '0;
            res.format = fmt;
            due_results.insert(due_results.size(), res);
            clear_parse();
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            clear_parse();
            due_results.delete();
        end else begin
            if (i_in_valid === 1'b1 && i_in_stall === 1'b0) parse_char(i_in);
            if (i_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                if (due_results.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result, no literal outstanding:", $time);
                    $display("    value %h status %0d format %0d",
                             i_out.value, i_out.status, i_out.format);
                end else begin
                    want = due_results.pop_front();
                    checked++;
                    if (i_out.value !== want.value) begin
                        fails++;
                        $display("%0t: value mismatch: expected %h, got %h",
                                 $time, want.value, i_out.value);
                    end
                    if (i_out.status !== want.status) begin
                        fails++;
                        $display("%0t: status mismatch: expected %0d, got %0d",
                                 $time, want.status, i_out.status);
                    end
                    if (i_out.format !== want.format) begin
                        fails++;
                        $display("%0t: format mismatch: expected %0d, got %0d",
                                 $time, want.format, i_out.format);
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= due_results.size();
        o_checked    <= checked;
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the literal parser. The checker beside the block
// does all the prediction and comparison; this module only feeds characters,
// stalls the result channel and decides the outcome at the end.
module tb_top
    import mrlp_pkg::*;
();

    // Shapes of literal that the random part draws from.
    typedef enum {
        LIT_HEX_PREFIX,
        LIT_HEX_SUFFIX,
        LIT_BIN_PREFIX,
        LIT_BIN_SUFFIX,
        LIT_DECIMAL,
        LIT_DEC_EDGE,
        LIT_NOISE
    } t_lit_kind;

    // Behaviours of the result receiver.
    typedef enum {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_BLOCKS
    } t_rx_mode;

    localparam int CHAR_TARGET = 1500;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    t_in      in_req = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    t_out     out_res;
    int       fail_count;
    int       pending;
    int       checked;

    logic [7:0] lit [$];
    int         chars_sent = 0;
    int         lits_sent = 0;
    int         burst_left = 0;
    bit         calm = 1'b0;
    t_rx_mode   rx_mode = RX_FREE;
    int         rx_left = 0;

    multi_radix_literal_parser u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_res)
    );

    literal_checker u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in         (in_req),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out        (out_res),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #1 clk = ~clk;

    // The receiver changes its habit every so often: sometimes it takes every
    // result at once, sometimes it stalls lightly or heavily, and sometimes it
    // holds off for several cycles in a row. Long holds fill the block's queue
    // and push the stall back onto the character channel.
    always @(negedge clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 200);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            RX_FREE:  out_stall <= 1'b0;
            RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            RX_HEAVY: out_stall <= ($urandom_range(0, 1) == 0);
            default:  out_stall <= ((rx_left % 9) < 6);
        endcase
    end

    function automatic logic [7:0] hex_char(int v, bit upper);
        if (v < 10) return 8'(8'h30 + v);
        return upper ? 8'(8'h41 + v - 10) : 8'(8'h61 + v - 10);
    endfunction

    // Mostly short bodies, now and then one right around the 64-bit boundary.
    function automatic int pick_len(int lo, int hi, int wide_lo, int wide_hi);
        return ($urandom_range(0, 9) < 8) ? $urandom_range(lo, hi)
                                           : $urandom_range(wide_lo, wide_hi);
    endfunction

    // Appends one character to the literal being built.
    task automatic add_char(logic [7:0] c);
        lit.insert(lit.size(), c);
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) add_char(s[i]);
    endtask

    // Digits of the given radix, letters in random case.
    task automatic push_digits(int n, int radix);
        for (int i = 0; i < n; i++) begin
            add_char(hex_char($urandom_range(0, radix - 1), $urandom_range(0, 1)));
        end
    endtask

    // Leading zeros must not count towards the width of the value.
    task automatic pad_zeros();
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) add_char("0");
        end
    endtask

    task automatic build_literal(t_lit_kind kind);
        logic [63:0] v;
        lit.delete();
        case (kind)
            LIT_HEX_PREFIX: begin
                push_text("0x");
                pad_zeros();
                push_digits(pick_len(0, 8, 15, 17), 16);
            end
            LIT_HEX_SUFFIX: begin
                pad_zeros();
                push_digits(pick_len(1, 8, 15, 17), 16);
                add_char($urandom_range(0, 1) ? 8'h48 : 8'h68);
            end
            LIT_BIN_PREFIX: begin
                push_text("0b");
                pad_zeros();
                push_digits(pick_len(0, 12, 62, 66), 2);
            end
            LIT_BIN_SUFFIX: begin
                pad_zeros();
                push_digits(pick_len(1, 12, 62, 66), 2);
                add_char($urandom_range(0, 1) ? 8'h42 : 8'h62);
            end
            LIT_DECIMAL: begin
                pad_zeros();
                if ($urandom_range(0, 3) == 0) begin
                    // Twenty or twenty-one significant digits: mostly too wide.
                    add_char(hex_char($urandom_range(1, 9), 1'b0));
                    push_digits($urandom_range(19, 20), 10);
                end else begin
                    v = {$urandom, $urandom} >> $urandom_range(0, 63);
                    push_text($sformatf("%0d", v));
                end
            end
            LIT_DEC_EDGE: begin
                // The ten values around the largest 64-bit number.
                pad_zeros();
                push_text("1844674407370955161");
                add_char(hex_char($urandom_range(0, 9), 1'b0));
            end
            default: begin
                repeat ($urandom_range(1, 5)) add_char(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    // Offers one character and holds it until the block takes the request.
    // Valid is only lowered at the start of a gap, never in the step that
    // raises it again.
    task automatic send_char(logic [7:0] c, logic fin);
        if (burst_left == 0) begin
            if (in_valid) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            burst_left = calm ? 400 : $urandom_range(1, 12);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_req   <= '{ch: c, last: fin};
        do @(posedge clk); while (in_stall !== 1'b0);
        @(negedge clk);
        chars_sent++;
    endtask

    task automatic send_literal();
        foreach (lit[i]) send_char(lit[i], i == lit.size() - 1);
        lits_sent++;
    endtask

    initial begin
        string     directed [10] = '{"0x", "h", "0b", "b", "1Fh", "0b10", "11b", "9z",
                                     "0xA", "0"};
        int        r;
        t_lit_kind kind;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: empty bodies under every prefix and suffix, one good
        // literal of each format, an illegal decimal character, and a lone
        // character with every bit set.
        foreach (directed[i]) begin
            lit.delete();
            push_text(directed[i]);
            send_literal();
        end
        lit.delete();
        add_char(8'hFF);
        send_literal();

        // Random part: mostly well-formed literals with random content, a share
        // of them corrupted in one place, and some pure noise. Stretches with
        // no sender gaps come and go.
        while (chars_sent < CHAR_TARGET) begin
            if ($urandom_range(0, 29) == 0) calm = !calm;
            r = $urandom_range(0, 99);
            if (r < 16)      kind = LIT_HEX_PREFIX;
            else if (r < 32) kind = LIT_HEX_SUFFIX;
            else if (r < 48) kind = LIT_BIN_PREFIX;
            else if (r < 62) kind = LIT_BIN_SUFFIX;
            else if (r < 78) kind = LIT_DECIMAL;
            else if (r < 88) kind = LIT_DEC_EDGE;
            else             kind = LIT_NOISE;
            build_literal(kind);
            if (kind != LIT_NOISE && $urandom_range(0, 7) == 0) begin
                lit[$urandom_range(0, lit.size() - 1)] = 8'($urandom_range(0, 255));
            end
            send_literal();
        end
        in_valid <= 1'b0;

        // Drain the outstanding results, then leave a few cycles in which any
        // stray result would still be caught.
        wait (pending == 0);
        repeat (10) @(posedge clk);

        $display("Fed %0d characters in %0d literals (all five formats, boundary widths,",
                 chars_sent, lits_sent);
        $display("corrupted literals and noise) under random gaps and stalls; %0d results checked.",
                 checked);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
sv/mrlp_pkg.sv
sv/mrlp_front.sv
sv/mrlp_queue.sv
sv/mrlp_back.sv
sv/multi_radix_literal_parser.sv
tb/literal_checker.sv
tb/tb_top.sv
